### src/marching_squares_cell_segments_top_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the marching squares cell unit
// Clocked property checks, compiled out when ASSERT_OFF is defined.
// ---------------------------------------------------------------------------
`ifndef MARCHING_SQUARES_CELL_SEGMENTS_TOP_DEFINES_SVH
`define MARCHING_SQUARES_CELL_SEGMENTS_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// implication checked at every edge outside reset
`define MSQ_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition that must never hold
`define MSQ_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define MSQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define MSQ_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

### src/msq_pkg.sv
// ---------------------------------------------------------------------------
// msq_pkg
// Shared types, constants and segment table of the marching squares unit.
// ---------------------------------------------------------------------------
package msq_pkg;

	localparam int MAX_COLUMNS_DEF   = 1024;
	localparam int MAX_ROWS_DEF      = 1024;
	localparam int FRACTION_BITS_DEF = 16;

	localparam int SMP_W   = 16;  // corner sample
	localparam int IDX_W   = 10;  // column / row
	localparam int MAG_W   = 16;  // |sample - level|
	localparam int DEN_W   = 17;  // |va - vb|
	localparam int CRD_W   = 32;  // output coordinate
	localparam int PITCH_W = 31;
	localparam int PROD_W  = IDX_W + PITCH_W;  // index * pitch
	localparam int BASE_W  = PROD_W + 2;       // origin + index * pitch, signed
	localparam int SUM_W   = BASE_W + 1;       // base + offset or pitch
	localparam int DIV_STEPS = 4;              // quotient bits per divider stage
	localparam int NEDGE   = 4;
	localparam int IN_W    = 88;
	localparam int OUT_W   = 128;
	localparam int CFG_AW  = 3;
	localparam int CFG_DW  = 32;

	localparam logic [CFG_AW-1:0] REG_LEVEL    = 3'd0;
	localparam logic [CFG_AW-1:0] REG_ORIGIN_X = 3'd1;
	localparam logic [CFG_AW-1:0] REG_ORIGIN_Y = 3'd2;
	localparam logic [CFG_AW-1:0] REG_PITCH_X  = 3'd3;
	localparam logic [CFG_AW-1:0] REG_PITCH_Y  = 3'd4;

	typedef enum logic [1:0] {
		E_LEFT   = 2'd0,
		E_BOTTOM = 2'd1,
		E_RIGHT  = 2'd2,
		E_TOP    = 2'd3
	} edge_t;

	typedef struct packed {
		logic signed [SMP_W-1:0] level;
		logic signed [CRD_W-1:0] origin_x;
		logic signed [CRD_W-1:0] origin_y;
		logic [PITCH_W-1:0]      pitch_x;
		logic [PITCH_W-1:0]      pitch_y;
	} cfg_t;

	typedef struct packed {
		logic [3:0]        cs;
		logic              upper;
		logic [PROD_W-1:0] prod_x;
		logic [PROD_W-1:0] prod_y;
	} front_t;

	typedef struct packed {
		logic [3:0]              cs;
		logic                    upper;
		logic signed [BASE_W-1:0] x0;
		logic signed [BASE_W-1:0] y0;
	} side_t;

	typedef struct packed {
		edge_t s0_a;
		edge_t s0_b;
		edge_t s1_a;
		edge_t s1_b;
		logic  two;
	} seg_plan_t;

	function automatic seg_plan_t seg_plan(input logic [3:0] cs, input logic upper);
		seg_plan_t p;
		p = '{E_LEFT, E_BOTTOM, E_TOP, E_RIGHT, 1'b0};
		case (cs)
			4'd1, 4'd14: p = '{E_LEFT, E_BOTTOM, E_TOP, E_RIGHT, 1'b0};
			4'd2, 4'd13: p = '{E_BOTTOM, E_RIGHT, E_TOP, E_RIGHT, 1'b0};
			4'd4, 4'd11: p = '{E_TOP, E_RIGHT, E_TOP, E_RIGHT, 1'b0};
			4'd7, 4'd8:  p = '{E_LEFT, E_TOP, E_TOP, E_RIGHT, 1'b0};
			4'd3, 4'd12: p = '{E_LEFT, E_RIGHT, E_TOP, E_RIGHT, 1'b0};
			4'd6, 4'd9:  p = '{E_BOTTOM, E_TOP, E_TOP, E_RIGHT, 1'b0};
			4'd5, 4'd10: begin
				// saddle: mean above the level joins the corners that are above
				if ((cs == 4'd5) == upper)
					p = '{E_LEFT, E_TOP, E_BOTTOM, E_RIGHT, 1'b1};
				else
					p = '{E_LEFT, E_BOTTOM, E_TOP, E_RIGHT, 1'b1};
			end
			default: p = '{E_LEFT, E_BOTTOM, E_TOP, E_RIGHT, 1'b0};
		endcase
		return p;
	endfunction

	function automatic logic [CRD_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] hi;
		logic signed [SUM_W-1:0] lo;
		hi = SUM_W'(32'sh7FFF_FFFF);
		lo = -SUM_W'(64'sh8000_0000);
		if (v > hi)
			return 32'h7FFF_FFFF;
		else if (v < lo)
			return 32'h8000_0000;
		else
			return v[CRD_W-1:0];
	endfunction

endpackage

### src/msq_front.sv
// ---------------------------------------------------------------------------
// msq_front
// Input stage: level-relative samples, cell case, saddle vote, grid check,
// divider operands and cell base products.
// ---------------------------------------------------------------------------
module msq_front import msq_pkg::*; #(
	parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
	parameter int MAX_ROWS    = MAX_ROWS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_vld,
	input  logic [IN_W-1:0]  in_data,
	input  cfg_t             cfg,
	output logic             vld_s1,
	output logic [MAG_W-1:0] num_s1 [NEDGE],
	output logic [DEN_W-1:0] den_s1 [NEDGE],
	output front_t           side_s1
);

	logic [IDX_W-1:0]        col;
	logic [IDX_W-1:0]        row;
	logic signed [SMP_W-1:0] raw [4];
	logic signed [SMP_W:0]   v [4];
	logic [3:0]              cs;
	logic signed [SMP_W+1:0] sum;
	logic signed [SMP_W+1:0] lvl4;
	logic                    in_grid;
	logic                    live;
	// corner pairs per edge: left a-d, bottom a-b, right b-c, top d-c
	localparam int EA [NEDGE] = '{0, 0, 1, 3};
	localparam int EB [NEDGE] = '{3, 1, 2, 2};

	assign col = in_data[IDX_W-1:0];
	assign row = in_data[2*IDX_W-1:IDX_W];

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			raw[k] = in_data[2*IDX_W + k*SMP_W +: SMP_W];
			v[k]   = (SMP_W+1)'(raw[k]) - (SMP_W+1)'(cfg.level);
			cs[k]  = v[k] > 0;
		end
		sum  = (SMP_W+2)'(raw[0]) + (SMP_W+2)'(raw[1]) + (SMP_W+2)'(raw[2])
			+ (SMP_W+2)'(raw[3]);
		lvl4 = (SMP_W+2)'(cfg.level) <<< 2;
		in_grid = (int'(col) <= MAX_COLUMNS - 2) && (int'(row) <= MAX_ROWS - 2);
		live = in_vld && in_grid && (cs != 4'd0) && (cs != 4'd15);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (en)
			vld_s1 <= live;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int e = 0; e < NEDGE; e++) begin
				logic signed [SMP_W+1:0] d;
				d = (SMP_W+2)'(v[EA[e]]) - (SMP_W+2)'(v[EB[e]]);
				num_s1[e] <= v[EA[e]] < 0 ? MAG_W'(-v[EA[e]]) : MAG_W'(v[EA[e]]);
				den_s1[e] <= d < 0 ? DEN_W'(-d) : DEN_W'(d);
			end
			side_s1.cs     <= cs;
			side_s1.upper  <= sum > lvl4;
			side_s1.prod_x <= PROD_W'(col) * PROD_W'(cfg.pitch_x);
			side_s1.prod_y <= PROD_W'(row) * PROD_W'(cfg.pitch_y);
		end
	end

endmodule

### src/msq_div.sv
// ---------------------------------------------------------------------------
// msq_div
// Pipelined restoring divider: q = floor(num * 2^FRACTION_BITS / den),
// valid while num <= den. DIV_STEPS quotient bits per stage.
// ---------------------------------------------------------------------------
module msq_div import msq_pkg::*; #(
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   en,
	input  logic [MAG_W-1:0]       num,
	input  logic [DEN_W-1:0]       den,
	output logic [FRACTION_BITS:0] quo
);

	localparam int QW  = FRACTION_BITS + 1;
	localparam int STG = (QW + DIV_STEPS - 1) / DIV_STEPS;
	localparam int RW  = DEN_W + 1;

	logic [RW-1:0]    rem_s [STG];
	logic [DEN_W-1:0] den_s [STG];
	logic [QW-1:0]    quo_s [STG];

	for (genvar k = 0; k < STG; k++) begin : g_stg
		logic [RW-1:0]    r_in;
		logic [DEN_W-1:0] d_in;
		logic [QW-1:0]    q_in;
		logic [RW-1:0]    r_nx;
		logic [QW-1:0]    q_nx;

		if (k == 0) begin : g_first
			assign r_in = RW'(num);
			assign d_in = den;
			assign q_in = '0;
		end else begin : g_next
			assign r_in = rem_s[k-1];
			assign d_in = den_s[k-1];
			assign q_in = quo_s[k-1];
		end

		always_comb begin
			r_nx = r_in;
			q_nx = q_in;
			for (int j = 0; j < DIV_STEPS; j++) begin
				if (k*DIV_STEPS + j < QW) begin
					// the integer bit needs no shift; remainder stays below den
					if (k*DIV_STEPS + j != 0)
						r_nx = {r_nx[RW-2:0], 1'b0};
					if (r_nx >= {1'b0, d_in}) begin
						r_nx = r_nx - {1'b0, d_in};
						q_nx = {q_nx[QW-2:0], 1'b1};
					end else begin
						q_nx = {q_nx[QW-2:0], 1'b0};
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= r_nx;
				den_s[k] <= d_in;
				quo_s[k] <= q_nx;
			end
		end
	end

	assign quo = quo_s[STG-1];

endmodule

### src/msq_back.sv
// ---------------------------------------------------------------------------
// msq_back
// Offset multiply, endpoint add and saturate, segment select and the
// output buffer that plays out one or two segments per item.
// ---------------------------------------------------------------------------
module msq_back import msq_pkg::*; #(
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   vld,
	input  logic [FRACTION_BITS:0] quo [NEDGE],
	input  side_t                  side,
	input  cfg_t                   cfg,
	output logic                   en,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_W-1:0]       m_axis_tdata,  // start_x, start_y, end_x, end_y
	output logic                   m_axis_tlast   // last_segment
);

	localparam int MUL_W = PITCH_W + FRACTION_BITS + 1;

	logic              vld_b1;
	logic [MUL_W-1:0]  prod_b1 [NEDGE];
	side_t             side_b1;
	logic              vld_b2;
	logic [CRD_W-1:0]  px_b2 [NEDGE];
	logic [CRD_W-1:0]  py_b2 [NEDGE];
	logic [3:0]        cs_b2;
	logic              upper_b2;
	logic [OUT_W-1:0]  seg0_q;
	logic [OUT_W-1:0]  seg1_q;
	logic              two_q;
	logic              idx_q;
	logic              ob_vld_q;
	seg_plan_t         plan;
	logic signed [SUM_W-1:0] x0;
	logic signed [SUM_W-1:0] y0;
	logic signed [SUM_W-1:0] off [NEDGE];
	logic signed [SUM_W-1:0] px_w [NEDGE];
	logic signed [SUM_W-1:0] py_w [NEDGE];

	assign m_axis_tvalid = ob_vld_q;
	assign m_axis_tlast  = !two_q || idx_q;
	assign m_axis_tdata  = idx_q ? seg1_q : seg0_q;
	assign en = !ob_vld_q || (m_axis_tready && m_axis_tlast);

	always_ff @(posedge clk) begin
		if (en) begin
			for (int e = 0; e < NEDGE; e++)
				prod_b1[e] <= (e == int'(E_LEFT) || e == int'(E_RIGHT))
					? MUL_W'(cfg.pitch_y) * MUL_W'(quo[e])
					: MUL_W'(cfg.pitch_x) * MUL_W'(quo[e]);
			side_b1 <= side;
		end
	end

	always_comb begin
		x0 = SUM_W'(side_b1.x0);
		y0 = SUM_W'(side_b1.y0);
		for (int e = 0; e < NEDGE; e++)
			off[e] = SUM_W'(prod_b1[e][FRACTION_BITS +: PITCH_W]);
		px_w[E_LEFT]   = x0;
		py_w[E_LEFT]   = y0 + off[E_LEFT];
		px_w[E_BOTTOM] = x0 + off[E_BOTTOM];
		py_w[E_BOTTOM] = y0;
		px_w[E_RIGHT]  = x0 + SUM_W'(cfg.pitch_x);
		py_w[E_RIGHT]  = y0 + off[E_RIGHT];
		px_w[E_TOP]    = x0 + off[E_TOP];
		py_w[E_TOP]    = y0 + SUM_W'(cfg.pitch_y);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int e = 0; e < NEDGE; e++) begin
				px_b2[e] <= sat32(px_w[e]);
				py_b2[e] <= sat32(py_w[e]);
			end
			cs_b2    <= side_b1.cs;
			upper_b2 <= side_b1.upper;
		end
	end

	assign plan = seg_plan(cs_b2, upper_b2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_b1   <= 1'b0;
			vld_b2   <= 1'b0;
			ob_vld_q <= 1'b0;
			idx_q    <= 1'b0;
		end else if (en) begin
			vld_b1   <= vld;
			vld_b2   <= vld_b1;
			ob_vld_q <= vld_b2;
			idx_q    <= 1'b0;
		end else if (m_axis_tready) begin
			// first of two segments taken
			idx_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			two_q  <= plan.two;
			seg0_q <= {py_b2[plan.s0_b], px_b2[plan.s0_b], py_b2[plan.s0_a], px_b2[plan.s0_a]};
			seg1_q <= {py_b2[plan.s1_b], px_b2[plan.s1_b], py_b2[plan.s1_a], px_b2[plan.s1_a]};
		end
	end

endmodule

### src/marching_squares_cell_segments_top.sv
// Stages: input, pipelined divider (4 bits a stage), multiply, add, output buffer.
// Throughput: one cell per cycle unless m_axis_tready holds the output off; a saddle
// cell stalls the input until both of its segments are taken.
// Reset clears all valid bits and loads the registers with their reset values
// (level 0, origin 0, pitch 1.0).
// ---------------------------------------------------------------------------
// marching_squares_cell_segments_top
// Marching squares isoline segments for one grid cell per item.
// ---------------------------------------------------------------------------
`include "marching_squares_cell_segments_top_defines.svh"

module marching_squares_cell_segments_top import msq_pkg::*; #(
	parameter int MAX_COLUMNS   = MAX_COLUMNS_DEF,
	parameter int MAX_ROWS      = MAX_ROWS_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_AW-1:0] cfg_index,
	input  logic [CFG_DW-1:0] cfg_data,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	// cell_col, cell_row, corner_a, corner_b, corner_c, corner_d, zero pad
	input  logic [IN_W-1:0]   s_axis_tdata,
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	// start_x, start_y, end_x, end_y
	output logic [OUT_W-1:0]  m_axis_tdata,
	output logic              m_axis_tlast  // last_segment
);

	localparam int STG = (FRACTION_BITS + DIV_STEPS) / DIV_STEPS;

	cfg_t                   cfg_q;
	logic                   en;
	logic                   vld_s1;
	logic [MAG_W-1:0]       num_s1 [NEDGE];
	logic [DEN_W-1:0]       den_s1 [NEDGE];
	front_t                 front_s1;
	logic [FRACTION_BITS:0] quo [NEDGE];
	side_t                  side_s [STG];
	logic                   vld_s [STG];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.level    <= '0;
			cfg_q.origin_x <= '0;
			cfg_q.origin_y <= '0;
			cfg_q.pitch_x  <= PITCH_W'(65536);
			cfg_q.pitch_y  <= PITCH_W'(65536);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LEVEL:    cfg_q.level    <= cfg_data[SMP_W-1:0];
				REG_ORIGIN_X: cfg_q.origin_x <= cfg_data;
				REG_ORIGIN_Y: cfg_q.origin_y <= cfg_data;
				REG_PITCH_X:  cfg_q.pitch_x  <= cfg_data[PITCH_W-1:0];
				REG_PITCH_Y:  cfg_q.pitch_y  <= cfg_data[PITCH_W-1:0];
				default: ;
			endcase
		end
	end

	assign s_axis_tready = en;

	msq_front #(
		.MAX_COLUMNS(MAX_COLUMNS),
		.MAX_ROWS   (MAX_ROWS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_vld (s_axis_tvalid),
		.in_data(s_axis_tdata),
		.cfg    (cfg_q),
		.vld_s1 (vld_s1),
		.num_s1 (num_s1),
		.den_s1 (den_s1),
		.side_s1(front_s1)
	);

	for (genvar e = 0; e < NEDGE; e++) begin : g_div
		msq_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
			.clk(clk),
			.en (en),
			.num(num_s1[e]),
			.den(den_s1[e]),
			.quo(quo[e])
		);
	end

	// sideband line alongside the divider; cell base added in its first stage
	for (genvar k = 0; k < STG; k++) begin : g_side
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k] <= 1'b0;
			else if (en)
				vld_s[k] <= (k == 0) ? vld_s1 : vld_s[k == 0 ? 0 : k-1];
		end
		if (k == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (en) begin
					side_s[k].cs    <= front_s1.cs;
					side_s[k].upper <= front_s1.upper;
					side_s[k].x0    <= BASE_W'(cfg_q.origin_x) + BASE_W'(front_s1.prod_x);
					side_s[k].y0    <= BASE_W'(cfg_q.origin_y) + BASE_W'(front_s1.prod_y);
				end
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (en)
					side_s[k] <= side_s[k-1];
			end
		end
	end

	msq_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.vld          (vld_s[STG-1]),
		.quo          (quo),
		.side         (side_s[STG-1]),
		.cfg          (cfg_q),
		.en           (en),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

	`MSQ_ASSERT_NEVER(a_hold_in, clk, arst_n, m_axis_tvalid && !m_axis_tlast && s_axis_tready, "input taken while first saddle segment pending")
	`MSQ_ASSERT(a_second_seg, clk, arst_n, m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid && m_axis_tlast, "second segment missing")
	`MSQ_ASSERT(a_free_out, clk, arst_n, !m_axis_tvalid |-> s_axis_tready, "pipeline stalled with empty output")

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the marching squares cell unit: cells are streamed
// in, segments are predicted in the bench and compared in order as they leave.
// ---------------------------------------------------------------------------
module tb;
	import msq_pkg::*;

	localparam int DRAIN = 40;

	typedef struct {
		logic [31:0] sx;
		logic [31:0] sy;
		logic [31:0] ex;
		logic [31:0] ey;
		logic        last;
	} seg_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [CFG_AW-1:0] cfg_index;
	logic [CFG_DW-1:0] cfg_data;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	logic [IN_W-1:0]   s_axis_tdata;
	logic              m_axis_tvalid;
	logic              m_axis_tready;
	logic [OUT_W-1:0]  m_axis_tdata;
	logic              m_axis_tlast;

	marching_squares_cell_segments_top uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
	);

	// bench copy of the registers
	longint lvl_m, orgx_m, orgy_m, pitx_m, pity_m;

	logic [IN_W-1:0] pending_cells[$];
	seg_t            segs_due[$];
	int  send_idle_pct, recv_stall_pct;
	int  hold_req, hold_seen, hold_cnt;
	int  errors, n_cells, n_segs, n_saddles, n_flat;
	logic cell_taken;

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	function automatic longint mag64(input longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic longint edge_offset(input longint pitch, input longint va,
			input longint vb);
		longint den, q;
		den = mag64(va - vb);
		if (den == 0)
			return 0;
		q = (mag64(va) << FRACTION_BITS_DEF) / den;
		return (pitch * q) >>> FRACTION_BITS_DEF;
	endfunction

	function automatic logic [31:0] clip32(input longint v);
		if (v > 64'sd2147483647)
			return 32'h7FFF_FFFF;
		if (v < -64'sd2147483648)
			return 32'h8000_0000;
		return v[31:0];
	endfunction

	task automatic edge_xy(input edge_t e, input longint x0, input longint y0,
			input longint v[4], output logic [31:0] px, output logic [31:0] py);
		longint x, y;
		x = x0;
		y = y0;
		case (e)
			E_LEFT:   y = y0 + edge_offset(pity_m, v[0], v[3]);
			E_BOTTOM: x = x0 + edge_offset(pitx_m, v[0], v[1]);
			E_RIGHT: begin
				x = x0 + pitx_m;
				y = y0 + edge_offset(pity_m, v[1], v[2]);
			end
			default: begin
				x = x0 + edge_offset(pitx_m, v[3], v[2]);
				y = y0 + pity_m;
			end
		endcase
		px = clip32(x);
		py = clip32(y);
	endtask

	task automatic push_seg(input edge_t e1, input edge_t e2, input longint x0,
			input longint y0, input longint v[4], input logic last);
		seg_t s;
		edge_xy(e1, x0, y0, v, s.sx, s.sy);
		edge_xy(e2, x0, y0, v, s.ex, s.ey);
		s.last = last;
		segs_due.push_back(s);
	endtask

	// expected segments of one accepted cell
	task automatic predict_cell(input logic [IN_W-1:0] d);
		longint col, row, x0, y0, sum;
		longint raw[4], v[4];
		logic [3:0] cs;
		logic up;
		col = d[9:0];
		row = d[19:10];
		n_cells++;
		if (col > MAX_COLUMNS_DEF - 2 || row > MAX_ROWS_DEF - 2) begin
			n_flat++;
			return;
		end
		cs = '0;
		for (int k = 0; k < 4; k++) begin
			raw[k] = longint'($signed(d[20 + 16*k +: 16]));
			v[k] = raw[k] - lvl_m;
			cs[k] = v[k] > 0;
		end
		x0 = orgx_m + col * pitx_m;
		y0 = orgy_m + row * pity_m;
		case (cs)
			4'd1, 4'd14: push_seg(E_LEFT, E_BOTTOM, x0, y0, v, 1'b1);
			4'd2, 4'd13: push_seg(E_BOTTOM, E_RIGHT, x0, y0, v, 1'b1);
			4'd4, 4'd11: push_seg(E_TOP, E_RIGHT, x0, y0, v, 1'b1);
			4'd7, 4'd8:  push_seg(E_LEFT, E_TOP, x0, y0, v, 1'b1);
			4'd3, 4'd12: push_seg(E_LEFT, E_RIGHT, x0, y0, v, 1'b1);
			4'd6, 4'd9:  push_seg(E_BOTTOM, E_TOP, x0, y0, v, 1'b1);
			4'd5, 4'd10: begin
				n_saddles++;
				sum = raw[0] + raw[1] + raw[2] + raw[3];
				up = sum > 4 * lvl_m;
				if ((cs == 4'd5) == up) begin
					push_seg(E_LEFT, E_TOP, x0, y0, v, 1'b0);
					push_seg(E_BOTTOM, E_RIGHT, x0, y0, v, 1'b1);
				end else begin
					push_seg(E_LEFT, E_BOTTOM, x0, y0, v, 1'b0);
					push_seg(E_TOP, E_RIGHT, x0, y0, v, 1'b1);
				end
			end
			default: n_flat++;
		endcase
	endtask

	// input side: accept and predict at the rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_taken <= 1'b0;
		end else begin
			cell_taken <= s_axis_tvalid && s_axis_tready;
			if (s_axis_tvalid && s_axis_tready)
				predict_cell(s_axis_tdata);
		end
	end

	// driver
	always @(negedge clk) begin
		if (arst_n && (!s_axis_tvalid || cell_taken)) begin
			if (pending_cells.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				s_axis_tdata  <= pending_cells.pop_front();
				s_axis_tvalid <= 1'b1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// receiver, with an occasional long hold-off
	always @(negedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_cnt  = 300;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= $urandom_range(99) >= recv_stall_pct;
		end
	end

	// monitor
	always @(posedge clk) begin
		seg_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (segs_due.size() == 0) begin
				$display("%0t: unexpected segment %h last %b", $time, m_axis_tdata,
					m_axis_tlast);
				errors++;
			end else begin
				e = segs_due.pop_front();
				n_segs++;
				if (m_axis_tdata[31:0] !== e.sx || m_axis_tdata[63:32] !== e.sy ||
						m_axis_tdata[95:64] !== e.ex || m_axis_tdata[127:96] !== e.ey ||
						m_axis_tlast !== e.last) begin
					$display("%0t: segment mismatch exp %h %h %h %h last %b", $time,
						e.sx, e.sy, e.ex, e.ey, e.last);
					$display("%0t:                  got %h %h %h %h last %b", $time,
						m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64],
						m_axis_tdata[127:96], m_axis_tlast);
					errors++;
				end
			end
		end
	end

	task automatic set_regs(input longint lv, input longint ox, input longint oy,
			input longint px, input longint py);
		logic [CFG_AW-1:0] idx[5];
		logic [31:0] val[5];
		idx = '{REG_LEVEL, REG_ORIGIN_X, REG_ORIGIN_Y, REG_PITCH_X, REG_PITCH_Y};
		val = '{lv[31:0], ox[31:0], oy[31:0], px[31:0], py[31:0]};
		for (int i = 0; i < 5; i++) begin
			@(negedge clk);
			cfg_we    <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
		end
		@(negedge clk);
		cfg_we <= 1'b0;
		lvl_m  = longint'($signed(lv[15:0]));
		orgx_m = longint'($signed(ox[31:0]));
		orgy_m = longint'($signed(oy[31:0]));
		pitx_m = px & 64'h7FFF_FFFF;
		pity_m = py & 64'h7FFF_FFFF;
	endtask

	function automatic logic [15:0] corner_val(input logic above, input int spread);
		longint c;
		c = above ? lvl_m + 1 + $urandom_range(spread) : lvl_m - $urandom_range(spread);
		if (c > 32767) c = 32767;
		if (c < -32768) c = -32768;
		return c[15:0];
	endfunction

	function automatic logic [IN_W-1:0] make_cell(input logic [9:0] col,
			input logic [9:0] row, input logic [3:0] cs, input int spread);
		logic [IN_W-1:0] d;
		d = '0;
		d[9:0]   = col;
		d[19:10] = row;
		for (int k = 0; k < 4; k++)
			d[20 + 16*k +: 16] = corner_val(cs[k], spread);
		return d;
	endfunction

	task automatic random_cells(input int n);
		logic [IN_W-1:0] d;
		logic [9:0] col, row;
		for (int i = 0; i < n; i++) begin
			col = ($urandom_range(19) == 0) ? 10'd1023 : 10'($urandom_range(1022));
			row = ($urandom_range(19) == 0) ? 10'd1023 : 10'($urandom_range(1022));
			if ($urandom_range(3) == 0) begin
				d = '0;
				d[19:0]  = {row, col};
				d[83:20] = {$urandom, $urandom};
			end else begin
				d = make_cell(col, row, 4'($urandom), $urandom_range(1) ? 300 : 65535);
			end
			pending_cells.push_back(d);
		end
	endtask

	task automatic drain;
		wait (pending_cells.size() == 0 && !s_axis_tvalid && segs_due.size() == 0);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic set_idling(input int s, input int r);
		send_idle_pct  = s;
		recv_stall_pct = r;
	endtask

	initial begin
		logic [IN_W-1:0] d;
		arst_n = 1'b0;
		cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
		s_axis_tvalid = 1'b0; s_axis_tdata = '0; m_axis_tready = 1'b0;
		hold_req = 0; hold_seen = 0; hold_cnt = 0;
		errors = 0; n_cells = 0; n_segs = 0; n_saddles = 0; n_flat = 0;
		set_idling(0, 0);
		lvl_m = 0; orgx_m = 0; orgy_m = 0; pitx_m = 65536; pity_m = 65536;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: every case at reset settings, grid edges, saddles both ways
		for (int c = 0; c < 16; c++)
			pending_cells.push_back(make_cell(10'($urandom_range(1022)),
				10'($urandom_range(1022)), 4'(c), 1000));
		pending_cells.push_back(make_cell(10'd0, 10'd0, 4'd1, 100));
		pending_cells.push_back(make_cell(10'd1022, 10'd1022, 4'd2, 100));
		pending_cells.push_back(make_cell(10'd1023, 10'd5, 4'd3, 100));
		pending_cells.push_back(make_cell(10'd5, 10'd1023, 4'd3, 100));
		d = '0;
		d[83:20] = {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000};  // saddle, sum below
		pending_cells.push_back(d);
		d[83:20] = {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF};
		pending_cells.push_back(d);
		d[83:20] = {16'h0001, 16'hFFFF, 16'h0003, 16'hFFFF};  // saddle, sum above
		pending_cells.push_back(d);
		d[83:20] = {16'hFFFF, 16'h0003, 16'hFFFF, 16'h0001};
		pending_cells.push_back(d);
		drain();

		// saturating coordinates, highest level
		set_regs(32767, 64'h7FFF_FFFF, 64'h7FFF_0000, 64'h7FFF_FFFF, 64'h7FFF_FFFF);
		set_idling(71, 0);
		random_cells(150);
		drain();

		set_regs(-32768, -64'sh8000_0000, -64'sh8000_0000, 1, 1);
		set_idling(0, 71);
		random_cells(200);
		drain();

		// back-pressure: output held off while cells keep coming
		set_regs($signed(16'($urandom)), $signed($urandom), $signed($urandom),
			$urandom_range(32'h7FFF_FFFF, 1), $urandom_range(32'h20000, 1));
		set_idling(0, 0);
		hold_req++;
		random_cells(200);
		drain();

		set_regs(0, 0, 0, 65536, 65536);
		set_idling(37, 37);
		random_cells(200);
		drain();

		set_regs($signed(16'($urandom)), $signed($urandom), $signed($urandom),
			$urandom_range(32'h40000, 1), $urandom_range(32'h7FFF_FFFF, 1));
		set_idling(0, 0);
		random_cells(200);
		drain();

		set_regs(0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		set_idling(37, 71);
		random_cells(180);
		drain();

		$display("cells %0d, segments %0d, saddles %0d, cells with no segment %0d",
			n_cells, n_segs, n_saddles, n_flat);
		$display("covered 7 register settings incl. extremes, idling and long hold-off");
		if (errors == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

	initial begin
		#5ms;
		$display("timeout");
		$display("tb NOT OK");
		$finish;
	end

endmodule
